// ===== src/lxn_pkg.sv =====
// Package for the two-line intersection block: widths, status codes, stage types
// and small helper functions. Depends on nothing; every other source file imports it.
`default_nettype none

package lxn_pkg;

	// Field widths at the ports.
	localparam int IN_W     = 32;
	localparam int OUT_W    = 48;
	localparam int LIMIT_W  = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd32440;

	// Coordinates are taken as their low CW bits, sign-extended.
	localparam int CW       = 32;
	// Fraction bits of a unit direction component.
	localparam int DF       = 30;

	// Derived widths.
	localparam int DXW      = CW + 1;              // point difference
	localparam int PB       = $clog2(DXW);         // bit position of a difference
	localparam int NORM_W   = 31;                  // normalized magnitude, top bit set
	localparam int SQ_W     = 2 * NORM_W;          // one square
	localparam int SUM_W    = SQ_W + 1;            // sum of squares
	localparam int RW       = (SUM_W + 1) / 2;     // square root
	localparam int UMW      = DF + 1;              // magnitude of a unit component
	localparam int DNUMW    = NORM_W + DF + 1;     // direction dividend
	localparam int UW       = DF + 2;              // signed unit component
	localparam int PW       = 2 * UW;              // product of two components
	localparam int ADW      = 2 * DF + 2;          // magnitude of the denominator
	localparam int NPW      = UW + DXW;            // component times point difference
	localparam int NW       = NPW + 1;             // numerator of t
	localparam int LOW_W    = 32;                  // low slice of the numerator
	localparam int HIW      = NW - LOW_W;          // high slice of the numerator
	localparam int OUT_FRAC = 8;
	localparam int NUMW     = NW + UMW + OUT_FRAC; // final dividend
	localparam int QW       = 62;                  // quotient bits below saturation
	localparam int VW       = QW + 2;              // placed coordinate before clamping
	localparam int LIMIT_SHIFT = 2 * DF - 15;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_ZERO     = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

	// Data that rides along with a line pair up to the products stage.
	typedef struct packed {
		logic                  zero;
		logic signed [CW-1:0]  p2x;
		logic signed [CW-1:0]  p2y;
		logic signed [DXW-1:0] ex;
		logic signed [DXW-1:0] ey;
	} side_t;

	// One line after normalization: signs and magnitudes, the larger in [2^30, 2^31).
	typedef struct packed {
		logic              sx;
		logic              sy;
		logic [NORM_W-1:0] ax;
		logic [NORM_W-1:0] ay;
	} line_t;

	// One lane of the square root pipeline.
	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [RW-1:0]    root;
		line_t            ln;
	} sqrt_t;

	// One component lane of the direction divider.
	typedef struct packed {
		logic [DNUMW-1:0] rem;
		logic [UMW-1:0]   q;
		logic [RW-1:0]    r;
		logic             s;
	} dcomp_t;

	// Data shared by both coordinates in the back half.
	typedef struct packed {
		logic [ADW-1:0]       aden;
		logic signed [CW-1:0] p2x;
		logic signed [CW-1:0] p2y;
		status_t              st;
	} fside_t;

	// One coordinate lane of the final divider.
	typedef struct packed {
		logic [NUMW-1:0] rem;
		logic [QW-1:0]   q;
		logic            neg;
		logic            ovf;
	} fdiv_t;

	// Take the low CW bits of a port field as a signed coordinate.
	function automatic logic signed [CW-1:0] coord(input logic [IN_W-1:0] v);
		return signed'(v[CW-1:0]);
	endfunction

	// Scale both magnitudes together so that the larger one has its top bit at 2^30.
	function automatic line_t norm_line(input logic signed [DXW-1:0] dx,
	                                    input logic signed [DXW-1:0] dy);
		logic [DXW-1:0] ax;
		logic [DXW-1:0] ay;
		logic [DXW-1:0] m;
		logic [PB-1:0]  p;
		line_t          o;
		ax = dx[DXW-1] ? DXW'(-dx) : DXW'(dx);
		ay = dy[DXW-1] ? DXW'(-dy) : DXW'(dy);
		m  = ax | ay;
		p  = '0;
		for (int b = 0; b < DXW; b++) begin
			if (m[b]) begin
				p = PB'(b);
			end
		end
		if (p >= PB'(NORM_W - 1)) begin
			o.ax = NORM_W'(ax >> (p - PB'(NORM_W - 1)));
			o.ay = NORM_W'(ay >> (p - PB'(NORM_W - 1)));
		end else begin
			o.ax = NORM_W'(ax << (PB'(NORM_W - 1) - p));
			o.ay = NORM_W'(ay << (PB'(NORM_W - 1) - p));
		end
		o.sx = dx[DXW-1];
		o.sy = dy[DXW-1];
		return o;
	endfunction

endpackage

`default_nettype wire

// ===== src/lxn_in_if.sv =====
// Input channel of the intersection block: one beat carries a pair of lines.
// Depends on lxn_pkg for the field width.
`default_nettype none

interface lxn_in_if;
	import lxn_pkg::*;

	logic             valid;
	logic             ready;
	logic [IN_W-1:0]  first_start_x;
	logic [IN_W-1:0]  first_start_y;
	logic [IN_W-1:0]  first_end_x;
	logic [IN_W-1:0]  first_end_y;
	logic [IN_W-1:0]  second_start_x;
	logic [IN_W-1:0]  second_start_y;
	logic [IN_W-1:0]  second_end_x;
	logic [IN_W-1:0]  second_end_y;

	modport source (
		output valid, first_start_x, first_start_y, first_end_x, first_end_y,
		       second_start_x, second_start_y, second_end_x, second_end_y,
		input  ready
	);

	modport sink (
		input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
		       second_start_x, second_start_y, second_end_x, second_end_y,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/lxn_out_if.sv =====
// Output channel of the intersection block: one beat carries a point and a status.
// Depends on lxn_pkg for the widths and the status type.
`default_nettype none

interface lxn_out_if;
	import lxn_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [OUT_W-1:0]  cross_x;
	logic signed [OUT_W-1:0]  cross_y;
	status_t                  status;

	modport source (output valid, cross_x, cross_y, status, input ready);
	modport sink   (input valid, cross_x, cross_y, status, output ready);
endinterface

`default_nettype wire

// ===== src/line_intersection_2d.sv =====
// Top level of the two-line intersection block, a single deep pipeline.
// Depends on lxn_pkg, lxn_in_if and lxn_out_if.
//
// Each input beat carries two lines as start and end points; each output beat
// carries the intersection in Q40.8 and a status (intersects, parallel,
// zero-length line, saturated). The block takes one beat per clock while the output
// is not stalled. Its pipeline holds bit-serial stages, 32 for the square root of
// each line's length, 31 for the unit-direction divide and 62 for the final divide,
// plus 11 stages of setup, products and output.
// The whole pipeline advances whenever the output register is empty or being
// drained, so a stall at the output holds every stage in place. parallel_limit is
// written through cfg_we/cfg_wdata and resets to 0.990 in Q1.15; write it only
// while no beats are in flight.
`default_nettype none

module line_intersection_2d (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lxn_pkg::LIMIT_W-1:0] cfg_wdata,
	lxn_in_if.sink                      in_ch,
	lxn_out_if.source                   out_ch
);
	import lxn_pkg::*;

	logic en;

	// Configuration register.
	logic [LIMIT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Output register and the global advance.
	logic                    out_v_q;
	logic signed [OUT_W-1:0] cx_q;
	logic signed [OUT_W-1:0] cy_q;
	status_t                 st_q;

	assign en          = !out_v_q || out_ch.ready;
	assign in_ch.ready = en;

	// Stage 1: differences and zero-length check.
	logic signed [DXW-1:0] dx_in [2];
	logic signed [DXW-1:0] dy_in [2];
	side_t                 side_in;

	always_comb begin
		dx_in[0] = DXW'(coord(in_ch.first_end_x)) - DXW'(coord(in_ch.first_start_x));
		dy_in[0] = DXW'(coord(in_ch.first_end_y)) - DXW'(coord(in_ch.first_start_y));
		dx_in[1] = DXW'(coord(in_ch.second_end_x)) - DXW'(coord(in_ch.second_start_x));
		dy_in[1] = DXW'(coord(in_ch.second_end_y)) - DXW'(coord(in_ch.second_start_y));
		side_in.p2x = coord(in_ch.second_start_x);
		side_in.p2y = coord(in_ch.second_start_y);
		side_in.ex  = DXW'(coord(in_ch.first_start_x)) - DXW'(coord(in_ch.second_start_x));
		side_in.ey  = DXW'(coord(in_ch.first_start_y)) - DXW'(coord(in_ch.second_start_y));
		side_in.zero = (dx_in[0] == '0 && dy_in[0] == '0) ||
		               (dx_in[1] == '0 && dy_in[1] == '0);
	end

	logic                  v_s1;
	logic signed [DXW-1:0] dx_s1 [2];
	logic signed [DXW-1:0] dy_s1 [2];
	side_t                 side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= dx_in;
			dy_s1   <= dy_in;
			side_s1 <= side_in;
		end
	end

	// Stage 2: normalize each line's direction.
	logic  v_s2;
	line_t ln_s2 [2];
	side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				ln_s2[l] <= norm_line(dx_s1[l], dy_s1[l]);
			end
			side_s2 <= side_s1;
		end
	end

	// Stage 3: squares of the normalized magnitudes.
	logic             v_s3;
	logic [SQ_W-1:0]  sqx_s3 [2];
	logic [SQ_W-1:0]  sqy_s3 [2];
	line_t            ln_s3 [2];
	side_t            side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				sqx_s3[l] <= ln_s2[l].ax * ln_s2[l].ax;
				sqy_s3[l] <= ln_s2[l].ay * ln_s2[l].ay;
				ln_s3[l]  <= ln_s2[l];
			end
			side_s3 <= side_s2;
		end
	end

	// Stage 4: sum of squares, loaded into the square root pipeline.
	logic  sqv_s    [RW+1];
	sqrt_t sqrt_s   [RW+1][2];
	side_t sqside_s [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv_s[0] <= 1'b0;
		end else if (en) begin
			sqv_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				sqrt_s[0][l].rem  <= SUM_W'(sqx_s3[l]) + SUM_W'(sqy_s3[l]);
				sqrt_s[0][l].root <= '0;
				sqrt_s[0][l].ln   <= ln_s3[l];
			end
			sqside_s[0] <= side_s3;
		end
	end

	// Square root, one result bit per stage, from the top bit down.
	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		localparam int B = RW - 1 - k;
		sqrt_t nxt [2];

		always_comb begin
			logic [SUM_W+1:0] t;
			for (int l = 0; l < 2; l++) begin
				nxt[l] = sqrt_s[k][l];
				t = ((SUM_W+2)'(sqrt_s[k][l].root) << (B + 1)) +
				    ((SUM_W+2)'(1) << (2 * B));
				if ((SUM_W+2)'(sqrt_s[k][l].rem) >= t) begin
					nxt[l].rem  = sqrt_s[k][l].rem - SUM_W'(t);
					nxt[l].root = sqrt_s[k][l].root | (RW'(1) << B);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[k+1] <= 1'b0;
			end else if (en) begin
				sqv_s[k+1] <= sqv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sqrt_s[k+1]   <= nxt;
				sqside_s[k+1] <= sqside_s[k];
			end
		end
	end

	// Direction divider setup: component * 2^DF plus half the length, per component.
	// Lanes are first x, first y, second x, second y.
	logic   dvv_s    [UMW+1];
	dcomp_t dv_s     [UMW+1][4];
	side_t  dvside_s [UMW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvv_s[0] <= 1'b0;
		end else if (en) begin
			dvv_s[0] <= sqv_s[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				dv_s[0][2*l].rem   <= (DNUMW'(sqrt_s[RW][l].ln.ax) << DF) +
				                      DNUMW'(sqrt_s[RW][l].root >> 1);
				dv_s[0][2*l].q     <= '0;
				dv_s[0][2*l].r     <= sqrt_s[RW][l].root;
				dv_s[0][2*l].s     <= sqrt_s[RW][l].ln.sx;
				dv_s[0][2*l+1].rem <= (DNUMW'(sqrt_s[RW][l].ln.ay) << DF) +
				                      DNUMW'(sqrt_s[RW][l].root >> 1);
				dv_s[0][2*l+1].q   <= '0;
				dv_s[0][2*l+1].r   <= sqrt_s[RW][l].root;
				dv_s[0][2*l+1].s   <= sqrt_s[RW][l].ln.sy;
			end
			dvside_s[0] <= sqside_s[RW];
		end
	end

	// Restoring divide by the length, one quotient bit per stage.
	for (genvar k = 0; k < UMW; k++) begin : g_ddiv
		localparam int B = DF - k;
		dcomp_t nxt [4];

		always_comb begin
			logic [DNUMW:0] d;
			for (int c = 0; c < 4; c++) begin
				nxt[c] = dv_s[k][c];
				d = (DNUMW+1)'(dv_s[k][c].r) << B;
				if ({1'b0, dv_s[k][c].rem} >= d) begin
					nxt[c].rem = dv_s[k][c].rem - DNUMW'(d);
					nxt[c].q   = dv_s[k][c].q | (UMW'(1) << B);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[k+1] <= 1'b0;
			end else if (en) begin
				dvv_s[k+1] <= dvv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k+1]     <= nxt;
				dvside_s[k+1] <= dvside_s[k];
			end
		end
	end

	// Stage: signed unit components.
	logic                 v_s6;
	logic signed [UW-1:0] u_s6 [4];
	side_t                side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= dvv_s[UMW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				u_s6[c] <= dv_s[UMW][c].s ? -signed'(UW'(dv_s[UMW][c].q))
				                          :  signed'(UW'(dv_s[UMW][c].q));
			end
			side_s6 <= dvside_s[UMW];
		end
	end

	// Stage: products for dot, denominator and the numerator of t.
	logic                  v_s7;
	logic signed [PW-1:0]  mxx_s7;
	logic signed [PW-1:0]  myy_s7;
	logic signed [PW-1:0]  myx_s7;
	logic signed [PW-1:0]  mxy_s7;
	logic signed [NPW-1:0] na_s7;
	logic signed [NPW-1:0] nb_s7;
	logic signed [UW-1:0]  u2x_s7;
	logic signed [UW-1:0]  u2y_s7;
	side_t                 side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mxx_s7  <= u_s6[0] * u_s6[2];
			myy_s7  <= u_s6[1] * u_s6[3];
			myx_s7  <= u_s6[1] * u_s6[2];
			mxy_s7  <= u_s6[0] * u_s6[3];
			na_s7   <= u_s6[1] * side_s6.ex;
			nb_s7   <= u_s6[0] * side_s6.ey;
			u2x_s7  <= u_s6[2];
			u2y_s7  <= u_s6[3];
			side_s7 <= side_s6;
		end
	end

	// Stage: sums, parallel test, status and magnitudes.
	logic signed [PW:0]   dot;
	logic signed [PW:0]   den;
	logic signed [NW-1:0] nsum;
	logic [PW:0]          adot;
	logic [PW:0]          alim;
	logic                 par;
	status_t              st_pre;

	always_comb begin
		dot  = (PW+1)'(mxx_s7) + (PW+1)'(myy_s7);
		den  = (PW+1)'(myx_s7) - (PW+1)'(mxy_s7);
		nsum = NW'(na_s7) - NW'(nb_s7);
		adot = dot[PW] ? $unsigned(-dot) : $unsigned(dot);
		alim = (PW+1)'(limit_q) << LIMIT_SHIFT;
		par  = (adot > alim) || (den == '0);
		priority if (side_s7.zero) begin
			st_pre = ST_ZERO;
		end else if (par) begin
			st_pre = ST_PARALLEL;
		end else begin
			st_pre = ST_OK;
		end
	end

	logic             v_s8;
	logic [NW-1:0]    nmag_s8;
	logic [UMW-1:0]   um_s8  [2];
	logic             neg_s8 [2];
	fside_t           fs_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s8    <= nsum[NW-1] ? NW'(-nsum) : NW'(nsum);
			um_s8[0]   <= u2x_s7[UW-1] ? UMW'(-u2x_s7) : UMW'(u2x_s7);
			um_s8[1]   <= u2y_s7[UW-1] ? UMW'(-u2y_s7) : UMW'(u2y_s7);
			neg_s8[0]  <= nsum[NW-1] ^ u2x_s7[UW-1] ^ den[PW];
			neg_s8[1]  <= nsum[NW-1] ^ u2y_s7[UW-1] ^ den[PW];
			fs_s8.aden <= den[PW] ? ADW'(-den) : ADW'(den);
			fs_s8.p2x  <= side_s7.p2x;
			fs_s8.p2y  <= side_s7.p2y;
			fs_s8.st   <= st_pre;
		end
	end

	// Stage: partial products of |N| times each second-line component.
	logic                  v_s9;
	logic [LOW_W+UMW-1:0]  plo_s9 [2];
	logic [HIW+UMW-1:0]    phi_s9 [2];
	logic                  neg_s9 [2];
	fside_t                fs_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 2; c++) begin
				plo_s9[c] <= nmag_s8[LOW_W-1:0] * um_s8[c];
				phi_s9[c] <= nmag_s8[NW-1:LOW_W] * um_s8[c];
				neg_s9[c] <= neg_s8[c];
			end
			fs_s9 <= fs_s8;
		end
	end

	// Stage: full dividend with the rounding half, loaded into the final divider.
	logic   fdv_s    [QW+1];
	fdiv_t  fd_s     [QW+1][2];
	fside_t fdside_s [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fdv_s[0] <= 1'b0;
		end else if (en) begin
			fdv_s[0] <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 2; c++) begin
				fd_s[0][c].rem <= (((NUMW'(phi_s9[c]) << LOW_W) + NUMW'(plo_s9[c]))
				                   << OUT_FRAC) + NUMW'(fs_s9.aden >> 1);
				fd_s[0][c].q   <= '0;
				fd_s[0][c].neg <= neg_s9[c];
				fd_s[0][c].ovf <= 1'b0;
			end
			fdside_s[0] <= fs_s9;
		end
	end

	// Restoring divide by |den|, one quotient bit per stage; the first stage also
	// flags a quotient that reaches 2^QW.
	for (genvar k = 0; k < QW; k++) begin : g_fdiv
		localparam int B = QW - 1 - k;
		fdiv_t nxt [2];

		always_comb begin
			for (int c = 0; c < 2; c++) begin
				nxt[c] = fd_s[k][c];
				if (k == 0) begin
					nxt[c].ovf = (fd_s[k][c].rem >> QW) >= NUMW'(fdside_s[k].aden);
				end
				if ((fd_s[k][c].rem >> B) >= NUMW'(fdside_s[k].aden)) begin
					nxt[c].rem = fd_s[k][c].rem - (NUMW'(fdside_s[k].aden) << B);
					nxt[c].q   = fd_s[k][c].q | (QW'(1) << B);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fdv_s[k+1] <= 1'b0;
			end else if (en) begin
				fdv_s[k+1] <= fdv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				fd_s[k+1]     <= nxt;
				fdside_s[k+1] <= fdside_s[k];
			end
		end
	end

	// Place the correction on the second start point and clamp to 48 bits.
	logic signed [VW-1:0]    pv    [2];
	logic signed [OUT_W-1:0] pval  [2];
	logic                    psat  [2];
	logic signed [OUT_W-1:0] cx_d;
	logic signed [OUT_W-1:0] cy_d;
	status_t                 st_d;

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			pv[c] = (VW'(c == 0 ? fdside_s[QW].p2x : fdside_s[QW].p2y) <<< OUT_FRAC) +
			        (fd_s[QW][c].neg ? -signed'(VW'(fd_s[QW][c].q))
			                         :  signed'(VW'(fd_s[QW][c].q)));
			psat[c] = 1'b1;
			priority if (fd_s[QW][c].ovf) begin
				pval[c] = fd_s[QW][c].neg ? OUT_MIN : OUT_MAX;
			end else if (pv[c] > VW'(OUT_MAX)) begin
				pval[c] = OUT_MAX;
			end else if (pv[c] < VW'(OUT_MIN)) begin
				pval[c] = OUT_MIN;
			end else begin
				pval[c] = OUT_W'(pv[c]);
				psat[c] = 1'b0;
			end
		end
		if (fdside_s[QW].st != ST_OK) begin
			cx_d = '0;
			cy_d = '0;
			st_d = fdside_s[QW].st;
		end else begin
			cx_d = pval[0];
			cy_d = pval[1];
			st_d = (psat[0] || psat[1]) ? ST_SAT : ST_OK;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= fdv_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_q <= cx_d;
			cy_q <= cy_d;
			st_q <= st_d;
		end
	end

	assign out_ch.valid   = out_v_q;
	assign out_ch.cross_x = cx_q;
	assign out_ch.cross_y = cy_q;
	assign out_ch.status  = st_q;

	// A line of nonzero length always has a root of at least 2^30.
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		sqv_s[RW] && !sqside_s[RW].zero |->
			sqrt_s[RW][0].root >= (RW'(1) << (NORM_W - 1)) &&
			sqrt_s[RW][1].root >= (RW'(1) << (NORM_W - 1)))
		else $error("square root below the normalized range");

	// Unit components never exceed one.
	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dvv_s[UMW] && !dvside_s[UMW].zero |->
			dv_s[UMW][0].q <= (UMW'(1) << DF) && dv_s[UMW][1].q <= (UMW'(1) << DF) &&
			dv_s[UMW][2].q <= (UMW'(1) << DF) && dv_s[UMW][3].q <= (UMW'(1) << DF))
		else $error("unit direction component above one");

	// Parallel and zero-length results carry the origin.
	a_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (st_q == ST_ZERO || st_q == ST_PARALLEL) |->
			cx_q == '0 && cy_q == '0)
		else $error("nonzero point with a parallel or zero-length status");

	// A saturated result has at least one coordinate on a bound.
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && st_q == ST_SAT |->
			cx_q == OUT_MAX || cx_q == OUT_MIN || cy_q == OUT_MAX || cy_q == OUT_MIN)
		else $error("saturated status without a clamped coordinate");

endmodule

`default_nettype wire
